// ===== rtl/sha_pkg.sv =====
// sha_pkg: shared types and constants for the streaming hasher
// round constants, initial hash values, front-to-back queue entry type
`timescale 1ns / 1ps
package sha_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  localparam int unsigned QDepth = 2;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction
endpackage

// ===== rtl/sha_front.sv =====
// sha_front: accepts items and queues them for the hashing engine
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sha_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output sha_pkg::item_t q_item
);
  localparam int unsigned QDepth = sha_pkg::QDepth;
  localparam int unsigned PW = $clog2(QDepth);

  sha_pkg::item_t mem_r [QDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != (PW+1)'(QDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];
  // items with neither flag carry no work and are dropped here
  assign push = in_valid && in_ready && (in_item.byte_valid || in_item.end_of_message);
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= in_item;
        wp_r <= (wp_r == PW'(QDepth-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) rp_r <= (rp_r == PW'(QDepth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("count slip");
endmodule

// ===== rtl/sha_core.sv =====
// sha_core: byte packing, padding, 64-round compression and digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  sha_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_word,
  output logic [2:0]     out_index,
  output logic           out_last
);
  typedef enum logic [2:0] {S_IDLE, S_PAD, S_SCHED, S_ROUND, S_FINAL, S_OUT} state_t;

  state_t state_r;
  logic [31:0] h_r [8];
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [63:0] bits_r;
  logic [5:0]  pos_r;
  logic [6:0]  rnd_r;
  logic        padding_r;
  logic        eom_r;
  logic        len_r;
  logic [2:0]  oi_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0, s1, wnew, big0, big1, ch, maj, t1, wcur;
  logic [7:0]  pb;
  logic [2:0]  lk;

  assign q_ready = (state_r == S_IDLE);
  assign wcur = w_r[0];
  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + big1 + ch + sha_pkg::round_k(rnd_r[5:0]) + wcur;
    big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    lk = pos_r[2:0];
    if (!len_r) pb = padding_r ? 8'h00 : 8'h80;
    else pb = bits_r[6'(63 - 8 * int'(lk)) -: 8];
  end

  // packing, padding, rounds and digest sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_h(3'(i));
      bits_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      padding_r <= 1'b0;
      eom_r <= 1'b0;
      len_r <= 1'b0;
      oi_r <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.byte_valid) begin
              w_r[pos_r[5:2]][5'(31 - 8 * int'(pos_r[1:0])) -: 8] <= q_item.data_byte;
              bits_r <= bits_r + 64'd8;
              pos_r <= pos_r + 1'b1;
            end
            padding_r <= 1'b0;
            eom_r <= q_item.end_of_message;
            len_r <= 1'b0;
            if (q_item.byte_valid && pos_r == 6'd63) state_r <= S_SCHED;
            else if (q_item.end_of_message) state_r <= S_PAD;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        S_PAD: begin
          w_r[pos_r[5:2]][5'(31 - 8 * int'(pos_r[1:0])) -: 8] <= pb;
          pos_r <= pos_r + 1'b1;
          if (!len_r) padding_r <= 1'b1;
          if (!len_r && padding_r && pos_r == 6'd55 && !pb[7]) len_r <= 1'b1;
          if (!len_r && !padding_r && pos_r == 6'd55) len_r <= 1'b1;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          if (pos_r == 6'd63) state_r <= S_SCHED;
        end
        S_SCHED: state_r <= S_ROUND;
        S_ROUND: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + big0 + maj;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 7'd63) state_r <= S_FINAL;
        end
        S_FINAL: begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i] + v_r[i];
          if (!eom_r) state_r <= S_IDLE;
          else if (len_r && pos_r == 6'd0) begin
            state_r <= S_OUT;
            out_valid <= 1'b1;
            oi_r <= '0;
          end else state_r <= S_PAD;
        end
        S_OUT: begin
          if (out_ready) begin
            oi_r <= oi_r + 1'b1;
            if (oi_r == 3'd7) begin
              out_valid <= 1'b0;
              state_r <= S_IDLE;
              for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_h(3'(i));
              bits_r <= '0;
              padding_r <= 1'b0;
              eom_r <= 1'b0;
              len_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_word  = v_r[oi_r];
  assign out_index = oi_r;
  assign out_last  = (oi_r == 3'd7);

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("output outside out state");
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rnd_r == '0) else $error("round count not cleared");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> pos_r == '0) else $error("digest before block aligned");
endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// sha256_stream_hasher: top level of the byte-stream sha-256 hasher
// depends on sha_pkg, sha_front, sha_core
// channel | direction | tdata fields (low first)              | tuser
// in_     | slave     | data_byte[7:0]                         | byte_valid ; tlast=end
// out_    | master    | digest_word[31:0]                      | word_index[2:0] ; tlast
// a byte item passes through the queue into the core; a full block then runs the
// round loop (one round a cycle), end of message adds padding bytes at one
// a cycle plus one or two further compressions, then eight output words
// synchronous active-low reset restores the initial hash; out stalls hold the word
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);
  sha_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item.data_byte = in_tdata;
  assign in_item.byte_valid = in_tuser;
  assign in_item.end_of_message = in_tlast;

  sha_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  sha_core u_core (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_word(out_tdata),
    .out_index(out_tuser), .out_last(out_tlast)
  );
endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for sha256_stream_hasher, byte stream in, digest words out
// depends on sha_pkg and the rtl; digests predicted by an in-bench sha-256 model
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  sha_pkg::item_t byte_items[$];
  digest_word_t   digest_fifo[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  int             hold_left;
  int             mismatches;
  int             failures;
  int             cycles;
  int             item_count;

  // running hash state of the bench model
  logic [31:0]     hv[8];
  logic [31:0]     blk[16];
  int              bpos;
  longint unsigned bit_len;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic run_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(6'(r)) + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
  endtask

  task automatic put_byte(input logic [7:0] b);
    blk[bpos / 4][8 * (3 - bpos % 4) +: 8] = b;
    bpos++;
    if (bpos == 64) begin
      run_block();
      bpos = 0;
    end
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hv[i] = sha_pkg::init_h(3'(i));
    bpos    = 0;
    bit_len = 0;
  endtask

  task automatic hash_item(input sha_pkg::item_t it);
    longint unsigned len;
    digest_word_t    d;
    if (it.byte_valid) begin
      put_byte(it.data_byte);
      bit_len += 8;
    end
    if (it.end_of_message) begin
      len = bit_len;
      put_byte(8'h80);
      if (bpos > 56) while (bpos != 0) put_byte(8'h00);
      while (bpos < 56) put_byte(8'h00);
      for (int k = 0; k < 8; k++) put_byte(8'(len >> (56 - 8 * k)));
      for (int k = 0; k < 8; k++) begin
        d.word = hv[k];
        d.idx  = 3'(k);
        d.last = (k == 7);
        digest_fifo = {digest_fifo, d};
      end
      restart_hash();
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic v, input logic l);
    sha_pkg::item_t it;
    it.data_byte      = b;
    it.byte_valid     = v;
    it.end_of_message = l;
    byte_items = {byte_items, it};
    if (v || l) item_count++;
  endtask

  // a message of n random bytes; the closing item carries a byte or stands alone
  task automatic push_message(input int n, input bit bare_end);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, !bare_end && (i == n - 1));
    end
    if (bare_end || n == 0) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_messages(input int budget);
    int target;
    int n;
    target = item_count + budget;
    while (item_count < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(20);
        6, 7: begin
          case ($urandom_range(5))
            0: n = 55; 1: n = 56; 2: n = 63; 3: n = 64; 4: n = 119;
            default: n = 120;
          endcase
        end
        default: n = $urandom_range(130);
      endcase
      push_message(n, $urandom_range(3) == 0);
    end
  endtask

  task automatic wait_drained();
    while (byte_items.size() != 0 || in_tvalid || digest_fifo.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    sha_pkg::item_t nx;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) hash_item(sha_pkg::item_t'({in_tdata, in_tuser, in_tlast}));
      if (!in_tvalid || in_tready) begin
        if (byte_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nx = byte_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nx.data_byte;
          in_tuser  <= nx.byte_valid;
          in_tlast  <= nx.end_of_message;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk) begin
    digest_word_t d;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (digest_fifo.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected word %h idx %0d last %b", out_tdata, out_tuser, out_tlast);
        end else begin
          d = digest_fifo.pop_front();
          if (out_tdata !== d.word || out_tuser !== d.idx || out_tlast !== d.last) begin
            mismatches++;
            failures++;
            if (mismatches <= 10)
              $display("mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                       d.word, d.idx, d.last, out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    mismatches = 0;
    failures = 0;
    cycles = 0;
    item_count = 0;
    restart_hash();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, extreme bytes, bare end, idle item
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    // receiver holds off while a long message streams in
    hold_left <= 1500;
    push_message(120, 1'b0);
    push_message(10, 1'b0);
    random_messages(20);
    wait_drained();

    send_idle_pct = 50;
    random_messages(70);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 50;
    random_messages(70);
    wait_drained();

    send_idle_pct = 18;
    recv_stall_pct = 18;
    random_messages(70);
    wait_drained();

    repeat (200) @(posedge clk);
    if (failures == 0 && digest_fifo.size() == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end
endmodule
